// ===== hdl/f2dt_pkg.sv =====
// Shared types and constants for the float to decimal text converter.
`timescale 1ns / 1ps

package f2dt_pkg;

   // Default fraction digit limit and the text length limit
   localparam int MAX_FRAC_DIGITS_DEF = 7;
   localparam int TEXT_BUFFER_LEN     = 15;

   // Integer part width and number of decimal digits it can need
   localparam int IPART_W    = 31;
   localparam int INT_DIGITS = 10;
   localparam int FPART_W    = 24;

   // Exponent field window that converts: unbiased -23 .. 30
   localparam int          EXP_BIAS = 127;
   localparam logic [7:0]  EXP_LO   = 8'(EXP_BIAS - 23);
   localparam logic [7:0]  EXP_HI   = 8'(EXP_BIAS + 31);

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_DOT   = 7'h2E;
   localparam logic [6:0] CHAR_NONE  = 7'h00;

   // What the output word carries
   typedef enum logic [2:0] {
      EMIT_FAIL,
      EMIT_SIGN,
      EMIT_INT,
      EMIT_DOT,
      EMIT_FRAC
   } emit_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic          load;
      logic          dabble;
      logic          measure;
      logic          frac_step;
      logic          emit;
      emit_kind_type kind;
      logic          last;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fail;
      logic neg;
      logic dabble_last;
      logic digit_last;
      logic frac_done;
      logic frac_last;
      logic no_frac;
   } dp_status_type;

endpackage

// ===== hdl/float_to_decimal_text.sv =====
// Top level of the single-precision float to decimal ASCII text converter.
`timescale 1ns / 1ps

// Takes one IEEE single-precision word and returns its decimal text as a run
// of ASCII words, tlast on the final character: optional '-', integer digits
// (or '0'), '.', then fraction digits made by truncating multiply-by-ten and
// trimmed of trailing zeros (one kept). Either zero gives "0.0". Infinities,
// NaNs, denormals and values with unbiased exponent outside -23..30 give one
// word with tuser (failed) set and char 0. One conversion runs at a time.
// After acceptance there is a class state, then shift-and-add-3 BCD
// conversion of the integer part and a measure state. Next come the
// fraction steps, as many as the digit limit (MAX_FRAC_DIGITS, or fewer
// when the text is long), and the check that ends them. Only then does the
// first character appear. Characters then leave one per cycle through the
// output register while rsp_tready holds, up to 14 of them. The input is
// taken again once the last character is in the output register.
module float_to_decimal_text #(
   parameter int MAX_FRAC_DIGITS = f2dt_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] float_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] char_code, [7] zero
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser    // failed
);
   import f2dt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [6:0]    char_code;

   f2dt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   f2dt_dpath #(
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_dpath (
      .clock      (clock),
      .float_bits (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .char_code  (char_code),
      .last       (rsp_tlast),
      .failed     (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, char_code};

endmodule

// ===== hdl/f2dt_dpath.sv =====
// Datapath: float unpacking, binary to BCD, fraction digits and output word register.
`timescale 1ns / 1ps

module f2dt_dpath #(
   parameter int MAX_FRAC_DIGITS = f2dt_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic                   clock,
   input  logic [31:0]            float_bits,
   input  f2dt_pkg::dp_cmd_type   cmd,
   output f2dt_pkg::dp_status_type status,
   output logic [6:0]             char_code,
   output logic                   last,
   output logic                   failed
);
   import f2dt_pkg::*;

   // count width holds 0..MAX, index width addresses the buffer
   localparam int FCW = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int FIW = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
   localparam logic [4:0] ROOM    = 5'(TEXT_BUFFER_LEN - 1);
   localparam logic [4:0] MAX5    = 5'(MAX_FRAC_DIGITS);
   localparam logic [4:0] STEP_END = 5'(IPART_W - 1);

   logic [IPART_W-1:0] ipart_ff, ipart_in;
   logic [FPART_W-1:0] fpart_ff, fpart_in;
   logic               neg_ff, neg_in;
   logic               fail_ff, fail_in;
   logic               fzero_ff, fzero_in;
   logic [4*INT_DIGITS-1:0] bcd_ff, bcd_in;
   logic [4:0]         step_ff, step_in;
   logic [3:0]         iptr_ff, iptr_in;
   logic [FCW-1:0]     budget_ff, budget_in;
   logic [FCW-1:0]     fcnt_ff, fcnt_in;
   logic [FCW-1:0]     keep_ff, keep_in;
   logic [FCW-1:0]     fptr_ff, fptr_in;
   logic [3:0]         fbuf_ff [MAX_FRAC_DIGITS];
   logic [6:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic               failw_ff, failw_in;

   // load-time decode
   logic [7:0]  exp_field;
   logic [23:0] mant;
   logic        is_zero;
   logic [5:0]  shamt;
   logic [76:0] wide;

   // dabble and measure helpers
   logic [4*INT_DIGITS-1:0] adj;
   logic [3:0]  lead_idx;
   logic [4:0]  text_len;
   logic [4:0]  room_left;
   logic [27:0] prod;
   logic [3:0]  fdigit;
   logic [FCW-1:0] fcount;
   logic [3:0]  int_digit;

   // unpack: shift mantissa into {ipart, fpart} fixed point
   always_comb begin
      exp_field = float_bits[30:23];
      mant      = {1'b1, float_bits[22:0]};
      is_zero   = (float_bits[30:0] == 31'd0);
      shamt     = 6'(exp_field - EXP_LO);
      wide      = {53'd0, mant} << shamt;
   end

   // add-3 correction ahead of each BCD shift
   always_comb begin
      for (int i = 0; i < INT_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // highest nonzero BCD digit; zero value shows one digit
   always_comb begin
      lead_idx = 4'd0;
      for (int i = 0; i < INT_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_idx = 4'(i);
         end
      end
      text_len = 5'(neg_ff) + 5'(lead_idx) + 5'd2;
      room_left = ROOM - text_len;
   end

   // one fraction digit: times ten, digit from the top
   always_comb begin
      prod   = {1'b0, fpart_ff, 3'b000} + {3'b000, fpart_ff, 1'b0};
      fdigit = prod[27:24];
   end

   // digits kept after trimming trailing zeros
   always_comb begin
      if (fzero_ff) begin
         fcount = FCW'(1);
      end else if (budget_ff == '0) begin
         fcount = '0;
      end else if (keep_ff == '0) begin
         fcount = FCW'(1);
      end else begin
         fcount = keep_ff;
      end
   end

   assign int_digit = bcd_ff[4*iptr_ff +: 4];

   // next-state logic
   always_comb begin
      ipart_in  = ipart_ff;
      fpart_in  = fpart_ff;
      neg_in    = neg_ff;
      fail_in   = fail_ff;
      fzero_in  = fzero_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      iptr_in   = iptr_ff;
      budget_in = budget_ff;
      fcnt_in   = fcnt_ff;
      keep_in   = keep_ff;
      fptr_in   = fptr_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      failw_in  = failw_ff;

      if (cmd.load) begin
         if (is_zero) begin
            ipart_in = '0;
            fpart_in = '0;
            neg_in   = 1'b0;
            fail_in  = 1'b0;
         end else begin
            ipart_in = wide[76:46];
            fpart_in = wide[45:22];
            neg_in   = float_bits[31];
            fail_in  = (exp_field >= EXP_HI) || (exp_field < EXP_LO);
         end
         fzero_in = is_zero || (wide[45:22] == '0);
         bcd_in   = '0;
         step_in  = '0;
         fcnt_in  = '0;
         keep_in  = '0;
         fptr_in  = '0;
      end

      if (cmd.dabble) begin
         bcd_in   = {adj[4*INT_DIGITS-2:0], ipart_ff[IPART_W-1]};
         ipart_in = {ipart_ff[IPART_W-2:0], 1'b0};
         step_in  = step_ff + 5'd1;
      end

      if (cmd.measure) begin
         iptr_in = lead_idx;
         if (text_len >= ROOM) begin
            budget_in = '0;
         end else if (room_left > MAX5) begin
            budget_in = FCW'(MAX_FRAC_DIGITS);
         end else begin
            budget_in = room_left[FCW-1:0];
         end
      end

      if (cmd.frac_step) begin
         fpart_in = prod[23:0];
         fcnt_in  = fcnt_ff + FCW'(1);
         if (fdigit != 4'd0) begin
            keep_in = fcnt_ff + FCW'(1);
         end
      end

      // output word register
      if (cmd.emit) begin
         last_in  = cmd.last;
         failw_in = 1'b0;
         case (cmd.kind)
            EMIT_FAIL: begin
               char_in  = CHAR_NONE;
               failw_in = 1'b1;
            end
            EMIT_SIGN: char_in = CHAR_MINUS;
            EMIT_INT: begin
               char_in = CHAR_ZERO | {3'b000, int_digit};
               iptr_in = iptr_ff - 4'd1;
            end
            EMIT_DOT: char_in = CHAR_DOT;
            EMIT_FRAC: begin
               char_in = CHAR_ZERO | {3'b000, fbuf_ff[fptr_ff[FIW-1:0]]};
               fptr_in = fptr_ff + FCW'(1);
            end
            default: char_in = CHAR_NONE;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      ipart_ff  <= ipart_in;
      fpart_ff  <= fpart_in;
      neg_ff    <= neg_in;
      fail_ff   <= fail_in;
      fzero_ff  <= fzero_in;
      bcd_ff    <= bcd_in;
      step_ff   <= step_in;
      iptr_ff   <= iptr_in;
      budget_ff <= budget_in;
      fcnt_ff   <= fcnt_in;
      keep_ff   <= keep_in;
      fptr_ff   <= fptr_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      failw_ff  <= failw_in;
   end

   // fraction digit buffer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
            fbuf_ff[i] <= 4'd0;
         end
      end else if (cmd.frac_step) begin
         fbuf_ff[fcnt_ff[FIW-1:0]] <= fdigit;
      end
   end

   // status back to the controller
   always_comb begin
      status.fail        = fail_ff;
      status.neg         = neg_ff;
      status.dabble_last = (step_ff == STEP_END);
      status.digit_last  = (iptr_ff == 4'd0);
      status.frac_done   = (fcnt_ff == budget_ff);
      status.frac_last   = (fptr_ff == fcount - FCW'(1));
      status.no_frac     = (fcount == '0);
   end

   assign char_code = char_ff;
   assign last      = last_ff;
   assign failed    = failw_ff;

endmodule

// ===== hdl/f2dt_ctrl.sv =====
// Controller: sequences unpack, BCD conversion, fraction digits and character output.
`timescale 1ns / 1ps

module f2dt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  f2dt_pkg::dp_status_type status,
   output f2dt_pkg::dp_cmd_type    cmd
);
   import f2dt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASS,
      S_ICONV,
      S_MEASURE,
      S_FCONV,
      S_SIGN,
      S_INT,
      S_DOT,
      S_FRAC,
      S_FAILW
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   // output register can take a word
   assign slot_free = !valid_ff || rsp_tready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.kind      = EMIT_FAIL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: state_in = status.fail ? S_FAILW : S_ICONV;
         S_ICONV: begin
            cmd.dabble = 1'b1;
            if (status.dabble_last) begin
               state_in = S_MEASURE;
            end
         end
         S_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = S_FCONV;
         end
         S_FCONV: begin
            if (status.frac_done) begin
               state_in = status.neg ? S_SIGN : S_INT;
            end else begin
               cmd.frac_step = 1'b1;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_SIGN;
               state_in = S_INT;
            end
         end
         S_INT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_INT;
               if (status.digit_last) begin
                  state_in = S_DOT;
               end
            end
         end
         S_DOT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_DOT;
               cmd.last = status.no_frac;
               state_in = status.no_frac ? S_IDLE : S_FRAC;
            end
         end
         S_FRAC: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_FRAC;
               cmd.last = status.frac_last;
               if (status.frac_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FAILW: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_FAIL;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // output valid flag
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule
